// ===== rtl/aabb_pairwise_collision_table_top_defines.svh =====
// ---------------------------------------------------------------------------
// aabb pairwise collision table: assertion macros
// checks are compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef AABB_PAIRWISE_COLLISION_TABLE_TOP_DEFINES_SVH
`define AABB_PAIRWISE_COLLISION_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define APCT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("apct assertion failed");
// implication checked at every edge out of reset
`define APCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("apct assertion failed");
`else
`define APCT_ASSERT(label, clk, rst_n, prop)
`define APCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/apct_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apct_pkg
// types and constants shared by the collision table modules
// ---------------------------------------------------------------------------
package apct_pkg;

    localparam int SLOT_W = 3;

    localparam logic [63:0] PAIR_MASK_RESET = 64'd7749154589440144810;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_SWEEP  = 2'd3;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_PAIR = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [2:0]         body_class;
        logic               has_callback;
        logic [2:0]         target_slot;
        logic [7:0]         type_mask;
    } t_op_in;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] second_slot;
        logic              ok;
        logic              last;
    } t_result;

    // one stored collider
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [2:0]         ctype;
        logic               notify;
    } t_slot_row;

    typedef struct packed {
        logic op_go;
        logic pair_clr;
        logic pair_adv;
        logic emit_ab;
        logic emit_ba;
        logic emit_done;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic ev_ab;
        logic ev_ba;
        logic pair_last;
    } t_dp_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SECOND,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/apct_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apct_datapath
// slot table, pair counters, overlap test and result register
// ---------------------------------------------------------------------------
module apct_datapath #(
    parameter int SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  apct_pkg::t_op_in  i_in_data,
    input  logic              i_cfg_we,
    input  logic [63:0]       i_cfg_data,
    input  apct_pkg::t_dp_cmd i_cmd,
    output apct_pkg::t_dp_stat o_stat,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output apct_pkg::t_result o_out_data
);
    import apct_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic [63:0]      r_pair_mask;
    logic [SLOTS-1:0] r_slot_valid;
    logic [SLOTS-1:0] r_slot_pending;
    logic [2:0]       r_slot_type [SLOTS];
    t_slot_row        r_mem [SLOTS];
    t_slot_row        r_rd_a;
    t_slot_row        r_rd_b;

    logic [IDX_W-1:0] r_pi;
    logic [IDX_W-1:0] r_pk;
    logic [IDX_W-1:0] n_pi;
    logic [IDX_W-1:0] n_pk;

    logic             r_out_valid;
    t_result          r_out;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             mark_hit;
    logic             out_free;
    logic             pair_last;
    logic             overlap;
    logic             ev_ab;
    logic             ev_ba;
    logic             out_load;
    t_result          out_next;
    t_slot_row        new_row;

    logic signed [16:0] a_l, a_r, a_t, a_b;
    logic signed [16:0] b_l, b_r, b_t, b_b;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_slot_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign mark_hit = ({1'b0, i_in_data.target_slot} < 4'(SLOTS))
                      && r_slot_valid[i_in_data.target_slot[IDX_W-1:0]];

    assign new_row = '{left:   i_in_data.left,
                       top:    i_in_data.top,
                       width:  i_in_data.width,
                       height: i_in_data.height,
                       ctype:  i_in_data.body_class,
                       notify: i_in_data.has_callback};

    // pair walk: (0,1) (0,2) .. (SLOTS-2,SLOTS-1), held on the last pair
    assign pair_last = (r_pi == IDX_W'(SLOTS - 2)) && (r_pk == IDX_W'(SLOTS - 1));

    always_comb begin
        n_pi = r_pi;
        n_pk = r_pk;
        if (i_cmd.pair_clr) begin
            n_pi = '0;
            n_pk = IDX_W'(1);
        end else if (i_cmd.pair_adv && !pair_last) begin
            if (r_pk == IDX_W'(SLOTS - 1)) begin
                n_pi = r_pi + IDX_W'(1);
                n_pk = r_pi + IDX_W'(2);
            end else begin
                n_pk = r_pk + IDX_W'(1);
            end
        end
    end

    // overlap with touching edges counted, 17 bit exact
    always_comb begin
        a_l = 17'(r_rd_a.left);
        a_t = 17'(r_rd_a.top);
        a_r = a_l + $signed({2'b00, r_rd_a.width});
        a_b = a_t + $signed({2'b00, r_rd_a.height});
        b_l = 17'(r_rd_b.left);
        b_t = 17'(r_rd_b.top);
        b_r = b_l + $signed({2'b00, r_rd_b.width});
        b_b = b_t + $signed({2'b00, r_rd_b.height});
        overlap = !((b_r < a_l) || (b_l > a_r) || (b_b < a_t) || (b_t > a_b));
    end

    assign ev_ab = r_slot_valid[r_pi] && r_slot_valid[r_pk] && overlap && r_rd_a.notify
                   && r_pair_mask[{r_rd_a.ctype, r_rd_b.ctype}];
    assign ev_ba = r_slot_valid[r_pi] && r_slot_valid[r_pk] && overlap && r_rd_b.notify
                   && r_pair_mask[{r_rd_b.ctype, r_rd_a.ctype}];

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        out_load = 1'b0;
        out_next = '{kind: KIND_DONE, first_slot: '0, second_slot: '0, ok: 1'b1, last: 1'b1};
        if (i_cmd.op_go) begin
            case (i_in_data.opcode)
                OP_ADD: begin
                    out_load = 1'b1;
                    out_next.kind       = KIND_ADD;
                    out_next.first_slot = free_found ? SLOT_W'(free_idx) : '0;
                    out_next.ok         = free_found;
                end
                OP_MARK, OP_REMOVE: begin
                    out_load = 1'b1;
                end
                default: begin
                    out_load = 1'b0;
                end
            endcase
        end else if (i_cmd.emit_ab || i_cmd.emit_ba) begin
            out_load = 1'b1;
            out_next.kind        = KIND_PAIR;
            out_next.first_slot  = i_cmd.emit_ab ? SLOT_W'(r_pi) : SLOT_W'(r_pk);
            out_next.second_slot = i_cmd.emit_ab ? SLOT_W'(r_pk) : SLOT_W'(r_pi);
            out_next.last        = 1'b0;
        end else if (i_cmd.emit_done) begin
            out_load = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_mask    <= PAIR_MASK_RESET;
            r_slot_valid   <= '0;
            r_slot_pending <= '0;
            r_pi           <= '0;
            r_pk           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pair_mask <= i_cfg_data;
            end
            r_pi <= n_pi;
            r_pk <= n_pk;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op_go) begin
                case (i_in_data.opcode)
                    OP_ADD: begin
                        if (free_found) begin
                            r_slot_valid[free_idx]   <= 1'b1;
                            r_slot_pending[free_idx] <= 1'b0;
                        end
                    end
                    OP_MARK: begin
                        if (mark_hit) begin
                            r_slot_pending[i_in_data.target_slot[IDX_W-1:0]] <= 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (r_slot_valid[i] && i_in_data.type_mask[r_slot_type[i]]) begin
                                r_slot_valid[i]   <= 1'b0;
                                r_slot_pending[i] <= 1'b0;
                            end
                        end
                    end
                    default: begin
                        // sweep: free the marked slots before the pair walk
                        r_slot_valid   <= r_slot_valid & ~r_slot_pending;
                        r_slot_pending <= '0;
                    end
                endcase
            end
        end
    end

    // slot payload and two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.op_go && (i_in_data.opcode == OP_ADD) && free_found) begin
            r_mem[free_idx]       <= new_row;
            r_slot_type[free_idx] <= i_in_data.body_class;
        end
        r_rd_a <= r_mem[n_pi];
        r_rd_b <= r_mem[n_pk];
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_stat = '{out_free: out_free, ev_ab: ev_ab, ev_ba: ev_ba, pair_last: pair_last};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/apct_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apct_ctrl
// sequencer for table ops and the pair sweep
// ---------------------------------------------------------------------------
module apct_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_opcode,
    output logic               o_in_stall,
    input  apct_pkg::t_dp_stat i_stat,
    output apct_pkg::t_dp_cmd  o_cmd
);
    import apct_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        adv        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    o_cmd.op_go = 1'b1;
                    if (i_opcode == OP_SWEEP) begin
                        o_cmd.pair_clr = 1'b1;
                        n_state        = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                if (i_stat.ev_ab) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_ab = 1'b1;
                        if (i_stat.ev_ba) begin
                            n_state = ST_SECOND;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                end else if (i_stat.ev_ba) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_ba = 1'b1;
                        adv           = 1'b1;
                    end
                end else begin
                    adv = 1'b1;
                end
            end
            ST_SECOND: begin
                // mirrored beat of the same pair
                if (i_stat.out_free) begin
                    o_cmd.emit_ba = 1'b1;
                    adv           = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (adv) begin
            if (i_stat.pair_last) begin
                n_state = ST_DONE;
            end else begin
                o_cmd.pair_adv = 1'b1;
                n_state        = ST_SWEEP;
            end
        end
    end

endmodule

// ===== rtl/aabb_pairwise_collision_table_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aabb_pairwise_collision_table_top
// collider table with add, mark, remove by type and overlap sweep
// ---------------------------------------------------------------------------
// Add, mark and remove each answer with one beat. A sweep accepts the op and
// frees the marked slots, then walks every slot pair i<k once, one pair per
// cycle through the overlap unit fed by the two read ports of the slot memory
// while no result beat waits on a stalled output: SLOTS*(SLOTS-1)/2 pairs (28
// for eight slots). A pair that reports in both directions takes an extra step
// for its mirrored beat, and the done beat follows the last pair. No new op is
// taken until the sweep's done beat is out.
`include "aabb_pairwise_collision_table_top_defines.svh"

module aabb_pairwise_collision_table_top #(
    parameter int SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  apct_pkg::t_op_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output apct_pkg::t_result o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [63:0]       i_cfg_data
);
    import apct_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    apct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    apct_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // a result beat is only loaded when the output register can take it
    `APCT_ASSERT_IMP(a_emit_has_room, i_clk, i_rst_n,
        cmd.emit_ab || cmd.emit_ba || cmd.emit_done || cmd.op_go, stat.out_free)
    // at most one beat source per cycle
    `APCT_ASSERT(a_one_source, i_clk, i_rst_n,
        $onehot0({cmd.op_go, cmd.emit_ab, cmd.emit_ba, cmd.emit_done}))
    // no new op while a sweep is running
    `APCT_ASSERT_IMP(a_accept_idle, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        !(cmd.pair_adv || cmd.emit_ab || cmd.emit_ba || cmd.emit_done))

endmodule
